### hw/rtl/ffc_pkg.sv
// Package: direction codes and conversion functions for the float format converter.
package ffc_pkg;

   localparam logic [2:0] FUNC_H2S  = 3'd0;
   localparam logic [2:0] FUNC_S2H  = 3'd1;
   localparam logic [2:0] FUNC_H2BF = 3'd2;
   localparam logic [2:0] FUNC_BF2H = 3'd3;
   localparam logic [2:0] FUNC_S2BF = 3'd4;
   localparam logic [2:0] FUNC_BF2S = 3'd5;

   localparam logic [7:0] REBIAS = 8'd112;  // 127 - 15

   function automatic logic [31:0] half_to_single(input logic [15:0] hv);
      logic        sgn;
      logic [4:0]  ex;
      logic [9:0]  fr;
      logic [3:0]  lz;
      logic [10:0] nf;
      logic [31:0] r;
      sgn = hv[15];
      ex  = hv[14:10];
      fr  = hv[9:0];
      lz  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (fr[i]) lz = 4'(10 - i);
      end
      nf = {1'b0, fr} << lz;
      if (ex == 5'd0) begin
         if (fr == 10'd0) r = {sgn, 31'd0};
         else r = {sgn, 8'(REBIAS + 8'd1 - {4'd0, lz}), nf[9:0], 13'd0};
      end else if (ex == 5'h1F) begin
         r = {sgn, 8'hFF, fr, 13'd0};
      end else begin
         r = {sgn, 8'(REBIAS + {3'd0, ex}), fr, 13'd0};
      end
      return r;
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] xv);
      logic        sgn;
      logic [7:0]  bex;
      logic [22:0] fr;
      logic [9:0]  ex;     // signed view: bex - 112
      logic [4:0]  sh;
      logic [23:0] m;
      logic [24:0] mr;
      logic [15:0] r;
      sgn = xv[31];
      bex = xv[30:23];
      fr  = xv[22:0];
      ex  = {2'b00, bex} - 10'd112;
      sh  = 5'(10'd1 - ex);
      m   = {1'b1, fr} >> sh;
      mr  = {1'b0, m} + (m[12] ? 25'h2000 : 25'd0);
      if (bex == 8'hFF && fr != 23'd0) begin
         r = {sgn, 5'h1F, 1'b1, fr[21:13]};
      end else if ($signed(ex) <= 0) begin
         if ($signed(ex) < -10) r = {sgn, 15'd0};
         else r = {sgn, 15'(mr[24:13])};
      end else if ($signed(ex) >= 31) begin
         r = {sgn, 15'h7C00};
      end else begin
         mr = {2'b0, fr} + (fr[12] ? 25'h2000 : 25'd0);
         r = {sgn, 15'({ex[4:0], 10'd0} + {4'd0, mr[23:13]})};
      end
      return r;
   endfunction

   function automatic logic [15:0] single_to_brain(input logic [31:0] xv);
      logic [31:0] s;
      s = xv + 32'h8000;
      if (xv[30:23] == 8'hFF && xv[22:0] != 23'd0) return xv[31:16] | 16'h0040;
      return s[31:16];
   endfunction

endpackage

### hw/rtl/float_format_converter_unit.sv
// Top level: registered binary32/binary16/bfloat16 format converter.
// Converts one value per transaction and accepts one transaction every clock
// cycle. Each value is held in the input register, then makes one pass through the
// conversion logic into the result register. Input is held back only while
// the result register is full and not being taken.
module float_format_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_converted
);
   logic        in_vld_ff, in_vld_in;
   logic [2:0]  func_ff;
   logic [31:0] operand_ff;
   logic        out_vld_ff, out_vld_in;
   logic [31:0] conv_ff;
   logic [31:0] conv;
   logic        out_load;

   ffc_core u_core (.func(func_ff), .operand(operand_ff), .converted(conv));

   assign out_load  = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || out_load;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !out_load);
   assign out_vld_in = out_load || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_valid && req_ready) begin
         func_ff    <= req_func;
         operand_ff <= req_operand;
      end
      if (out_load) conv_ff <= conv;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_converted = conv_ff;
endmodule

### hw/rtl/ffc_core.sv
// Conversion datapath: one direction selected per transaction, pure logic.
module ffc_core (
   input  logic [2:0]  func,
   input  logic [31:0] operand,
   output logic [31:0] converted
);
   always_comb begin
      case (func)
         ffc_pkg::FUNC_H2S:  converted = ffc_pkg::half_to_single(operand[15:0]);
         ffc_pkg::FUNC_S2H:  converted = {16'd0, ffc_pkg::single_to_half(operand)};
         ffc_pkg::FUNC_H2BF:
            converted = {16'd0,
               ffc_pkg::single_to_brain(ffc_pkg::half_to_single(operand[15:0]))};
         ffc_pkg::FUNC_BF2H:
            converted = {16'd0, ffc_pkg::single_to_half({operand[15:0], 16'd0})};
         ffc_pkg::FUNC_S2BF: converted = {16'd0, ffc_pkg::single_to_brain(operand)};
         ffc_pkg::FUNC_BF2S: converted = {operand[15:0], 16'd0};
         default:            converted = 32'd0;
      endcase
   end
endmodule

### hw/rtl/ffc_checker.sv
// Port-level checker for the float format converter, bound to the top level.
module ffc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_converted
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_converted))
      else $error("result dropped or changed while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");
   // first edge out of reset: output register was cleared by the last reset edge
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind float_format_converter_unit ffc_checker u_ffc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_converted(rsp_converted)
);

### sim/testbench.sv
// Testbench for the float format converter: random and directed conversions vs. a predictor.
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [31:0] req_operand = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_converted;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] operand;
   } conv_item_type;

   conv_item_type pending_q[$];
   logic [31:0]   expected_q[$];
   int            mismatches = 0;
   int            checked = 0;
   int            idle_pct = 0;
   int            stall_pct = 0;
   bit            hold_off = 1'b0;

   float_format_converter_unit DUT (.*);

   always #10 clock = ~clock;

   // binary16 -> binary32, exact
   function automatic logic [31:0] widen_half(input logic [15:0] hv);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] fr;
      int          k;
      sgn = {hv[15], 31'd0};
      ex  = hv[14:10];
      fr  = {1'b0, hv[9:0]};
      k   = 0;
      if (ex == 5'd0) begin
         if (fr == 11'd0) return sgn;
         while (!fr[10] && k < 11) begin
            fr = fr << 1;
            k++;
         end
         return sgn | (32'(113 - k) << 23) | ({22'd0, fr[9:0]} << 13);
      end
      if (ex == 5'h1F) return sgn | 32'h7F80_0000 | ({22'd0, fr[9:0]} << 13);
      return sgn | (32'(ex + 112) << 23) | ({22'd0, fr[9:0]} << 13);
   endfunction

   // binary32 -> binary16, round half up on magnitude
   function automatic logic [31:0] narrow_single(input logic [31:0] xv);
      logic [31:0] sgn;
      logic [31:0] fr;
      logic [31:0] m;
      int          ex;
      sgn = {16'd0, xv[31], 15'd0};
      fr  = {9'd0, xv[22:0]};
      ex  = int'(xv[30:23]) - 112;
      if (xv[30:23] == 8'hFF && fr != 0) return sgn | 32'h7E00 | ((fr >> 13) & 32'h3FF);
      if (ex <= 0) begin
         if (ex < -10) return sgn;
         m = (fr | 32'h0080_0000) >> (1 - ex);
         if (m[12]) m = m + 32'h2000;
         return sgn | (m >> 13);
      end
      if (ex >= 31) return sgn | 32'h7C00;
      if (fr[12]) fr = fr + 32'h2000;
      return sgn | ((32'(ex) << 10) + (fr >> 13));
   endfunction

   function automatic logic [31:0] round_brain(input logic [31:0] xv);
      logic [31:0] s;
      if (xv[30:23] == 8'hFF && xv[22:0] != 0) return {16'd0, xv[31:16] | 16'h0040};
      s = xv + 32'h8000;
      return {16'd0, s[31:16]};
   endfunction

   function automatic logic [31:0] predict_conversion(input conv_item_type it);
      logic [15:0] lo;
      lo = it.operand[15:0];
      case (it.func)
         ffc_pkg::FUNC_H2S:  return widen_half(lo);
         ffc_pkg::FUNC_S2H:  return narrow_single(it.operand);
         ffc_pkg::FUNC_H2BF: return round_brain(widen_half(lo));
         ffc_pkg::FUNC_BF2H: return narrow_single({lo, 16'd0});
         ffc_pkg::FUNC_S2BF: return round_brain(it.operand);
         ffc_pkg::FUNC_BF2S: return {lo, 16'd0};
         default:            return 32'd0;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_q.push_back(predict_conversion({req_func, req_operand}));
         if (pending_q.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
            req_valid   <= 1'b1;
            req_func    <= pending_q[0].func;
            req_operand <= pending_q[0].operand;
            void'(pending_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction: %h", rsp_converted);
            end else begin
               if (rsp_converted !== expected_q[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h actual %h", expected_q[0], rsp_converted);
               end
               void'(expected_q.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(7))
         0: v[30:23] = 8'hFF;
         1: v[30:23] = 8'd0;
         2: v[30:23] = 8'($urandom_range(97, 127));  // binary16 subnormal and edge range
         3: v[30:23] = 8'($urandom_range(140, 145)); // near binary16 overflow
         4: v[14:10] = 5'h1F;
         5: v[14:10] = 5'd0;
         6: v[12:0] = 13'h1000 | 13'($urandom_range(1));
         default: ;
      endcase
      return v;
   endfunction

   task automatic drain();
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] directed[$];
      int          phase;
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0001, 32'h7F80_2000, 32'h477F_F000, 32'h477F_E000,
                   32'h3380_0000, 32'h3300_0000, 32'h0000_0001, 32'h3F80_1000,
                   32'hFFFF_FFFF, 32'hABCD_7C01, 32'h0000_03FF, 32'h0000_0001,
                   32'h0000_7BFF, 32'h0000_FC00, 32'h0000_7FFF, 32'h387F_F000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int f = 0; f < 8; f++)
         foreach (directed[i]) pending_q.push_back({3'(f), directed[i]});
      drain();
      for (phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 58 : 31) : 0;
         stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 58 : 31) : 0;
         repeat (240) pending_q.push_back({3'($urandom_range(7)), random_operand()});
         if (phase == 1) begin
            // let the pipeline empty fully before refilling
            while (pending_q.size() > 120) @(posedge clock);
            hold_off = 1'b1;
            while (req_valid || expected_q.size() > 0) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end
      repeat (10) @(posedge clock);
      $display("Ran 1120 conversions across all directions, NaN/Inf/subnormal edges,");
      $display("under four sender/receiver stall mixes; %0d results checked.", checked);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/ffc_pkg.sv
hw/rtl/ffc_core.sv
hw/rtl/float_format_converter_unit.sv
hw/rtl/ffc_checker.sv
sim/testbench.sv
